// ===== rtl/core/ssc_pkg.sv =====
// Shared types, command codes and step table for the six-step commutator.
package ssc_pkg;

    // Command bytes of the serial frame
    localparam logic [7:0] CMD_REPORT = 8'h5A;
    localparam logic [7:0] CMD_FWD    = 8'h39;
    localparam logic [7:0] CMD_REV    = 8'h35;
    localparam logic [7:0] CMD_POWER  = 8'h20;

    localparam logic [9:0]  DUTY_RESET          = 10'd350;
    localparam logic [15:0] RAMP_PERIOD_RESET   = 16'd100;
    localparam logic [7:0]  FRAME_TIMEOUT_RESET = 8'd100;
    localparam logic [7:0]  IDLE_MAX            = 8'd255;

    // Configuration register indexes
    localparam logic [7:0] CFG_RAMP_PERIOD   = 8'd0;
    localparam logic [7:0] CFG_FRAME_TIMEOUT = 8'd1;

    // Item kind carried in tuser
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    // Class of a command byte, worked out at the input side
    typedef enum logic [2:0] {
        CLS_OTHER  = 3'd0,
        CLS_FWD    = 3'd1,
        CLS_REV    = 3'd2,
        CLS_POWER  = 3'd3,
        CLS_REPORT = 3'd4
    } byte_cls_t;

    // Rotation direction
    typedef enum logic [1:0] {
        ROT_HOLD = 2'd0,
        ROT_FWD  = 2'd1,
        ROT_REV  = 2'd2
    } rotation_t;

    // One queued item after classification
    typedef struct packed {
        logic      is_byte;
        byte_cls_t cls;
        logic [7:0] data;
    } item_t;

    // Handshake between queue and back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

    // Drive pattern of one commutation step
    typedef struct packed {
        logic [7:0] high_mask;
        logic [7:0] low_pattern;
    } step_drive_t;

    // Step table, steps one to six; anything else drives as step one
    function automatic step_drive_t step_drive(input logic [2:0] step);
        step_drive_t d;
        unique case (step)
            3'd2:    d = '{high_mask: 8'b10001000, low_pattern: 8'b00100000};
            3'd3:    d = '{high_mask: 8'b10000010, low_pattern: 8'b00100000};
            3'd4:    d = '{high_mask: 8'b10000010, low_pattern: 8'b00000100};
            3'd5:    d = '{high_mask: 8'b10100000, low_pattern: 8'b00000100};
            3'd6:    d = '{high_mask: 8'b10100000, low_pattern: 8'b00000001};
            default: d = '{high_mask: 8'b10001000, low_pattern: 8'b00000001};
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/ssc_front.sv =====
// Input side: classifies each accepted item into a queue entry.
module ssc_front (
    input  logic          s_tuser,  // [0] kind: 0 timer tick, 1 serial byte
    input  logic [7:0]    s_tdata,  // [7:0] rx_byte
    output ssc_pkg::item_t item
);
    import ssc_pkg::*;

    byte_cls_t cls;

    // Decode the command byte once, ahead of the back end
    always_comb begin
        unique case (s_tdata)
            CMD_FWD:    cls = CLS_FWD;
            CMD_REV:    cls = CLS_REV;
            CMD_POWER:  cls = CLS_POWER;
            CMD_REPORT: cls = CLS_REPORT;
            default:    cls = CLS_OTHER;
        endcase
    end

    assign item.is_byte = (s_tuser == KIND_BYTE);
    assign item.cls     = cls;
    assign item.data    = s_tdata;

endmodule

// ===== rtl/core/ssc_queue.sv =====
// Two-entry queue between the input side and the back end.
module ssc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ssc_pkg::item_t       push_item,
    output logic                 not_full,
    input  logic                 pop,
    output ssc_pkg::queue_out_t  head
);
    import ssc_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign not_full   = (count_reg != 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/ssc_back.sv =====
// Back end: ramp, commutation, frame decode and the result register.
module ssc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  ssc_pkg::queue_out_t head,
    output logic                pop,
    input  logic [15:0]         ramp_period,
    input  logic [7:0]          frame_timeout,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata
);
    import ssc_pkg::*;

    logic [2:0]  step_phase_reg, step_phase_next;
    rotation_t   rotation_reg, rotation_next;
    logic [7:0]  target_reg, target_next;
    logic [8:0]  ramped_reg, ramped_next;
    logic [15:0] ramp_ticks_reg, ramp_ticks_next;
    logic [8:0]  step_ticks_reg, step_ticks_next;
    logic [7:0]  idle_reg, idle_next;
    logic [1:0]  frame_pos_reg, frame_pos_next;
    byte_cls_t   frame_cls_reg, frame_cls_next;
    logic [7:0]  frame_arg_reg, frame_arg_next;
    logic [9:0]  duty_reg, duty_next;
    logic [7:0]  high_mask_reg, high_mask_next;
    logic [7:0]  low_pattern_reg, low_pattern_next;
    logic        indicator_reg, indicator_next;
    logic        out_valid_reg;
    logic [47:0] out_data_reg;

    logic        fired;
    logic [16:0] ramp_sum;
    logic [8:0]  step_sum;
    logic [2:0]  step_safe;
    step_drive_t drive;
    logic        restart;
    logic [1:0]  pos_eff;
    logic [9:0]  duty_out;
    logic [47:0] result;

    // Take an item whenever the result register is free or being emptied
    assign pop      = head.valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign ramp_sum  = {1'b0, ramp_ticks_reg} + 17'd1;
    assign step_sum  = step_ticks_reg + 9'd1;
    assign step_safe = (step_phase_reg < 3'd1 || step_phase_reg > 3'd6) ? 3'd1
                                                                       : step_phase_reg;
    assign drive     = step_drive(step_safe);
    assign restart   = (idle_reg > frame_timeout);
    assign pos_eff   = restart ? 2'd0 : frame_pos_reg;

    // Work out the state after this item
    always_comb begin
        step_phase_next  = step_phase_reg;
        rotation_next    = rotation_reg;
        target_next      = target_reg;
        ramped_next      = ramped_reg;
        ramp_ticks_next  = ramp_ticks_reg;
        step_ticks_next  = step_ticks_reg;
        idle_next        = idle_reg;
        frame_pos_next   = frame_pos_reg;
        frame_cls_next   = frame_cls_reg;
        frame_arg_next   = frame_arg_reg;
        duty_next        = duty_reg;
        high_mask_next   = high_mask_reg;
        low_pattern_next = low_pattern_reg;
        indicator_next   = indicator_reg;
        fired            = 1'b0;

        if (!head.item.is_byte) begin
            // Timer tick: idle count, ramp, step counter
            if (idle_reg < IDLE_MAX) begin
                idle_next = idle_reg + 8'd1;
            end
            if (ramp_sum > {1'b0, ramp_period}) begin
                ramp_ticks_next = 16'd0;
                // Equal period still steps up
                if (ramped_reg > {1'b0, target_reg}) begin
                    ramped_next = ramped_reg - 9'd1;
                end else begin
                    ramped_next = ramped_reg + 9'd1;
                end
            end else begin
                ramp_ticks_next = ramp_sum[15:0];
            end
            step_ticks_next = step_sum;
            if (step_sum >= ramped_next) begin
                high_mask_next   = drive.high_mask;
                low_pattern_next = drive.low_pattern;
                step_phase_next  = step_safe;
                if (rotation_reg == ROT_FWD) begin
                    step_phase_next = (step_safe == 3'd6) ? 3'd1 : step_safe + 3'd1;
                end else if (rotation_reg == ROT_REV) begin
                    step_phase_next = (step_safe == 3'd1) ? 3'd6 : step_safe - 3'd1;
                end
                step_ticks_next = 9'd0;
                fired           = 1'b1;
            end
        end else begin
            // Serial byte: restart a stale frame, store, then decode the frame
            if (restart) begin
                frame_cls_next = CLS_OTHER;
                frame_arg_next = 8'd0;
            end
            if (pos_eff == 2'd0) begin
                frame_cls_next = head.item.cls;
                idle_next      = 8'd0;
            end else if (pos_eff == 2'd1) begin
                frame_arg_next = head.item.data;
                idle_next      = 8'd0;
            end
            frame_pos_next = (pos_eff < 2'd2) ? pos_eff + 2'd1 : pos_eff;

            unique case (frame_cls_next)
                CLS_FWD: begin
                    target_next   = frame_arg_next;
                    rotation_next = ROT_FWD;
                end
                CLS_REV: begin
                    target_next    = frame_arg_next;
                    rotation_next  = ROT_REV;
                    indicator_next = ~indicator_reg;
                end
                CLS_POWER: begin
                    duty_next = {frame_arg_next, 2'b00};
                end
                default: begin
                end
            endcase
        end
    end

    // Pack the result: phase, masks, period, duty, flags, direction
    assign duty_out = (target_next == 8'd0) ? 10'd0 : duty_next;
    assign result = {5'd0,
                     rotation_next,
                     indicator_next,
                     (frame_cls_next == CLS_REPORT),
                     fired,
                     duty_out,
                     ramped_next,
                     low_pattern_next,
                     high_mask_next,
                     step_phase_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_phase_reg  <= 3'd1;
            rotation_reg    <= ROT_REV;
            target_reg      <= 8'd0;
            ramped_reg      <= 9'd0;
            ramp_ticks_reg  <= 16'd0;
            step_ticks_reg  <= 9'd0;
            idle_reg        <= 8'd0;
            frame_pos_reg   <= 2'd0;
            frame_cls_reg   <= CLS_OTHER;
            frame_arg_reg   <= 8'd0;
            duty_reg        <= DUTY_RESET;
            high_mask_reg   <= 8'd0;
            low_pattern_reg <= 8'd0;
            indicator_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                step_phase_reg  <= step_phase_next;
                rotation_reg    <= rotation_next;
                target_reg      <= target_next;
                ramped_reg      <= ramped_next;
                ramp_ticks_reg  <= ramp_ticks_next;
                step_ticks_reg  <= step_ticks_next;
                idle_reg        <= idle_next;
                frame_pos_reg   <= frame_pos_next;
                frame_cls_reg   <= frame_cls_next;
                frame_arg_reg   <= frame_arg_next;
                duty_reg        <= duty_next;
                high_mask_reg   <= high_mask_next;
                low_pattern_reg <= low_pattern_next;
                indicator_reg   <= indicator_next;
                out_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= result;
        end
    end

endmodule

// ===== rtl/core/six_step_commutator_with_ramp.sv =====
// Top level of the open-loop six-step commutator with period ramp.
//
// Input stream (s_): each item is a timer tick (tuser 0) or a received
// serial byte (tuser 1, byte in tdata). Every item yields exactly one
// result on the output stream (m_): step number, held drive masks, ramped
// period, duty, commutation flag, report flag, indicator and direction.
// Configuration channel: cfg_index 0 writes the ramp period, 1 the frame
// timeout; other indexes are ignored. cfg_ready is always high.
//
// Flow: the accepting edge writes the item into the two-entry queue; the
// back end then pops it and runs its state update into the result
// register, which offers the result on m_. The back end takes one item
// per cycle while the result register is free or being taken (m_tready).
//
// Reset (aresetn low, synchronous) empties the queue and result register and
// loads the state: step one, reverse rotation, period zero, duty 350.
// When m_tready is low the result holds, the back end stops, and the queue
// absorbs up to two more items before s_tready drops.
module six_step_commutator_with_ramp (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] kind (0 tick, 1 serial byte)
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] phase, [10:3] high_side_mask, [18:11] low_side_pattern,
    // [27:19] period_now, [37:28] drive_duty, [38] commutated,
    // [39] report_request, [40] indicator, [42:41] turn_direction, [47:43] zero
    output logic [47:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ssc_pkg::*;

    item_t       front_item;
    queue_out_t  queue_head;
    logic        queue_not_full;
    logic        back_pop;
    logic [15:0] ramp_period_reg;
    logic [7:0]  frame_timeout_reg;

    assign s_tready  = queue_not_full;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_period_reg   <= RAMP_PERIOD_RESET;
            frame_timeout_reg <= FRAME_TIMEOUT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_RAMP_PERIOD) begin
                ramp_period_reg <= cfg_data;
            end else if (cfg_index == CFG_FRAME_TIMEOUT) begin
                frame_timeout_reg <= cfg_data[7:0];
            end
        end
    end

    ssc_front u_front (
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .item    (front_item)
    );

    ssc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid && queue_not_full),
        .push_item (front_item),
        .not_full  (queue_not_full),
        .pop       (back_pop),
        .head      (queue_head)
    );

    ssc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (queue_head),
        .pop           (back_pop),
        .ramp_period   (ramp_period_reg),
        .frame_timeout (frame_timeout_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule
